// ----- rtl/csc_sparse_matrix_vector_multiply_unit_macros.svh -----
// ----------------------------------------------------------------------------
// CSC sparse matrix-vector unit assertion macros
// Concurrent checks clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef CSC_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH
`define CSC_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define CSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// expression must never be true out of reset
`define CSC_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define CSC_ASSERT(label, prop, msg)
`define CSC_NEVER(label, expr, msg)
`endif

`endif

// ----- rtl/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// CSC sparse matrix-vector package
// Shared widths, codes, the multiplier request type and saturating add.
// ----------------------------------------------------------------------------
package csc_pkg;

    localparam int DEF_MAX_DIM     = 64;
    localparam int DEF_MAX_NONZERO = 4096;

    localparam int VAL_W  = 32;
    localparam int SUM_W  = 56;
    localparam int PROD_W = 48;
    localparam int IDX_W  = 6;
    localparam int OP_W   = 3;
    localparam int STS_W  = 2;
    localparam int DIMR_W = 7;
    localparam int THR_W  = 31;
    localparam int CFGI_W = 2;

    // command codes carried in tuser of the input channel
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_LOAD   = 3'd2,
        OP_XM     = 3'd3,
        OP_MX     = 3'd4
    } op_t;

    // status codes of single status results
    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_ORDER = 2'd1,
        STS_FULL  = 2'd2,
        STS_RANGE = 2'd3
    } status_t;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_ROWS   = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_THRESH = 2'd2;

    // operands for the shared multiplier
    typedef struct packed {
        logic                    en;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
    } mul_req_t;

    // add a product into a Q39.16 sum, clamping at the 56-bit range
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  acc,
        input logic signed [PROD_W-1:0] d
    );
        logic signed [SUM_W:0] s;
        s = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - PROD_W){d[PROD_W-1]}}, d};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

// ----- rtl/csc_mul.sv -----
// ----------------------------------------------------------------------------
// CSC product stage
// Registered 32x32 signed multiply, floored to Q.16 by dropping 16 bits.
// ----------------------------------------------------------------------------
module csc_mul (
    input  logic                                aclk,
    input  csc_pkg::mul_req_t                   req,
    output logic signed [csc_pkg::PROD_W-1:0]   prod
);
    import csc_pkg::*;

    logic signed [2*VAL_W-1:0]  full_prod;
    logic signed [PROD_W-1:0]   prod_reg;

    // arithmetic drop of the low bits is a floor in two's complement
    assign full_prod = req.a * req.b;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= full_prod[2*VAL_W-1:16];
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/csc_sparse_matrix_vector_multiply_unit.sv -----
// ----------------------------------------------------------------------------
// CSC sparse matrix-vector multiply unit
// Builds a column-compressed matrix and runs x'M and Mx products over it.
// ----------------------------------------------------------------------------
// Clear, insert and load commands each give one status item; a new command
// is taken every cycle while no product runs and the result side keeps up.
// Products walk the stored nonzeros one at a time, each nonzero costing an
// entry read, an operand read, a multiply and an accumulate. Entries whose
// row is at or above row_count are skipped after the entry read. No clearing
// pass is needed after reset.
`include "csc_sparse_matrix_vector_multiply_unit_macros.svh"

module csc_sparse_matrix_vector_multiply_unit #(
    parameter int MAX_DIM     = csc_pkg::DEF_MAX_DIM,
    parameter int MAX_NONZERO = csc_pkg::DEF_MAX_NONZERO
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input item
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [47:0]                    s_tdata,  // row_position, col_position, item_value
    input  logic [csc_pkg::OP_W-1:0]       s_tuser,  // opcode
    // result item
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,  // out_index, out_sum
    output logic                           m_tlast,  // is_last
    output logic [csc_pkg::STS_W-1:0]      m_tuser,  // status
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [csc_pkg::CFGI_W-1:0]     cfg_index,
    input  logic [csc_pkg::THR_W-1:0]      cfg_data
);
    import csc_pkg::*;

    localparam int CI_W   = $clog2(MAX_DIM);
    localparam int DC_W   = $clog2(MAX_DIM + 1);
    localparam int AW     = $clog2(MAX_NONZERO);
    localparam int NZ_W   = $clog2(MAX_NONZERO + 1);
    localparam int COL_DW = NZ_W + DC_W;
    localparam int ENT_DW = IDX_W + VAL_W;

    typedef enum logic [3:0] {
        S_IDLE, S_COL_RD, S_COL_WAIT, S_ENT_RD, S_ENT_WAIT,
        S_MUL, S_ACC, S_COL_END, S_OUT_RD, S_OUT_WAIT
    } state_t;

    // configuration
    logic [DIMR_W-1:0] row_count_reg, col_count_reg;
    logic [THR_W-1:0]  thresh_reg;
    logic [DC_W-1:0]   rows, cols;

    // control and datapath registers
    state_t                   state_reg, state_next;
    logic                     mode_mx_reg, mode_mx_next;
    logic [CI_W-1:0]          idx_reg, idx_next;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;
    logic [AW-1:0]            ptr_reg, ptr_next;
    logic [DC_W-1:0]          rem_reg, rem_next;
    logic [CI_W-1:0]          er_reg, er_next;
    logic signed [VAL_W-1:0]  val_reg, val_next;
    logic signed [VAL_W-1:0]  vcol_reg, vcol_next;
    logic                     open_reg, open_next;
    logic [IDX_W-1:0]         open_col_reg, open_col_next;
    logic [NZ_W-1:0]          open_start_reg, open_start_next;
    logic [DC_W-1:0]          open_fill_reg, open_fill_next;
    logic [NZ_W-1:0]          entry_total_reg, entry_total_next;
    logic [MAX_DIM-1:0]       col_valid_reg, col_valid_next;
    logic [MAX_DIM-1:0]       sum_valid_reg, sum_valid_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]         out_idx_reg, out_idx_next;
    logic signed [SUM_W-1:0]  out_sum_reg, out_sum_next;
    logic                     out_last_reg, out_last_next;
    status_t                  out_sts_reg, out_sts_next;

    // memories
    logic [COL_DW-1:0]        col_mem [MAX_DIM];
    logic [ENT_DW-1:0]        ent_mem [MAX_NONZERO];
    logic signed [VAL_W-1:0]  vec_mem [MAX_DIM];
    logic signed [SUM_W-1:0]  sum_mem [MAX_DIM];
    logic [COL_DW-1:0]        col_q_reg;
    logic [ENT_DW-1:0]        ent_q_reg;
    logic signed [VAL_W-1:0]  vec_q_reg;
    logic signed [SUM_W-1:0]  sum_q_reg;

    logic                     col_we, col_re, ent_we, ent_re, vec_we, vec_re, sum_we, sum_re;
    logic [CI_W-1:0]          col_waddr, col_raddr, vec_waddr, vec_raddr, sum_waddr, sum_raddr;
    logic [AW-1:0]            ent_waddr, ent_raddr;
    logic [COL_DW-1:0]        col_wdata;
    logic [ENT_DW-1:0]        ent_wdata;
    logic signed [VAL_W-1:0]  vec_wdata;
    logic signed [SUM_W-1:0]  sum_wdata;

    // multiplier
    mul_req_t                 mul_req;
    logic signed [PROD_W-1:0] prod;

    // input fields
    op_t                      in_op;
    logic [IDX_W-1:0]         in_row, in_col;
    logic signed [VAL_W-1:0]  in_value;
    logic                     s_acc, out_free;

    // insert decision
    logic                     ins_range_bad, ins_order_bad, ins_opening;
    logic                     ins_kept, ins_full, ins_store, ins_apply;
    logic [DC_W-1:0]          fill_cur, fill_new;
    logic [NZ_W-1:0]          start_cur;
    logic [VAL_W:0]           ins_mag;
    status_t                  ins_sts;

    // run helpers
    logic [DC_W-1:0]          col_fill_q;
    logic [NZ_W-1:0]          col_start_q;
    logic [IDX_W-1:0]         ent_row_q;
    logic signed [VAL_W-1:0]  ent_val_q;
    logic                     col_last, row_last, ent_last, row_skip;

    assign in_op    = op_t'(s_tuser);
    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[11:6];
    assign in_value = s_tdata[43:12];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_sum_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_sts_reg;

    // dimension registers clamp to 1 .. MAX_DIM
    assign rows = (row_count_reg == '0) ? DC_W'(1) :
                  (32'(row_count_reg) > MAX_DIM) ? DC_W'(MAX_DIM) : DC_W'(row_count_reg);
    assign cols = (col_count_reg == '0) ? DC_W'(1) :
                  (32'(col_count_reg) > MAX_DIM) ? DC_W'(MAX_DIM) : DC_W'(col_count_reg);

    // insert checks
    assign ins_range_bad = (32'(in_row) >= 32'(rows)) || (32'(in_col) >= 32'(cols));
    assign ins_order_bad = open_reg && (in_col < open_col_reg);
    assign ins_opening   = !open_reg || (in_col > open_col_reg);
    assign fill_cur      = ins_opening ? '0 : open_fill_reg;
    assign start_cur     = ins_opening ? entry_total_reg : open_start_reg;
    assign ins_mag       = in_value[VAL_W-1] ? ((VAL_W+1)'(0) - {in_value[VAL_W-1], in_value})
                                             : {1'b0, in_value};
    assign ins_kept      = ins_mag > {2'b00, thresh_reg};
    assign ins_full      = (32'(entry_total_reg) >= MAX_NONZERO) || (32'(fill_cur) >= MAX_DIM);
    assign ins_store     = ins_kept && !ins_full;
    assign ins_apply     = !ins_range_bad && !ins_order_bad;
    assign fill_new      = ins_store ? fill_cur + 1'b1 : fill_cur;

    always_comb begin
        priority if (ins_range_bad) begin
            ins_sts = STS_RANGE;
        end else if (ins_order_bad) begin
            ins_sts = STS_ORDER;
        end else if (ins_kept && ins_full) begin
            ins_sts = STS_FULL;
        end else begin
            ins_sts = STS_OK;
        end
    end

    // fields of memory read data
    assign col_fill_q  = col_q_reg[DC_W-1:0];
    assign col_start_q = col_q_reg[COL_DW-1:DC_W];
    assign ent_row_q   = ent_q_reg[IDX_W-1:0];
    assign ent_val_q   = ent_q_reg[ENT_DW-1:IDX_W];
    assign col_last    = (32'(idx_reg) + 1) == 32'(cols);
    assign row_last    = (32'(idx_reg) + 1) == 32'(rows);
    assign ent_last    = rem_reg == DC_W'(1);
    assign row_skip    = 32'(ent_row_q) >= 32'(rows);

    // next-state and memory control
    always_comb begin
        state_next       = state_reg;
        mode_mx_next     = mode_mx_reg;
        idx_next         = idx_reg;
        acc_next         = acc_reg;
        ptr_next         = ptr_reg;
        rem_next         = rem_reg;
        er_next          = er_reg;
        val_next         = val_reg;
        vcol_next        = vcol_reg;
        open_next        = open_reg;
        open_col_next    = open_col_reg;
        open_start_next  = open_start_reg;
        open_fill_next   = open_fill_reg;
        entry_total_next = entry_total_reg;
        col_valid_next   = col_valid_reg;
        sum_valid_next   = sum_valid_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_idx_next     = out_idx_reg;
        out_sum_next     = out_sum_reg;
        out_last_next    = out_last_reg;
        out_sts_next     = out_sts_reg;

        col_we = 1'b0; col_waddr = in_col[CI_W-1:0];
        col_wdata = {start_cur, fill_new};
        col_re = 1'b0; col_raddr = idx_reg;
        ent_we = 1'b0; ent_waddr = entry_total_reg[AW-1:0];
        ent_wdata = {in_value, in_row};
        ent_re = 1'b0; ent_raddr = ptr_reg;
        vec_we = 1'b0; vec_waddr = in_row[CI_W-1:0]; vec_wdata = in_value;
        vec_re = 1'b0; vec_raddr = idx_reg;
        sum_we = 1'b0; sum_waddr = er_reg;
        sum_wdata = sat_add(sum_valid_reg[er_reg] ? sum_q_reg : '0, prod);
        sum_re = 1'b0; sum_raddr = idx_reg;

        mul_req.en = 1'b0;
        mul_req.a  = mode_mx_reg ? vcol_reg : vec_q_reg;
        mul_req.b  = val_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (in_op)
                        OP_CLEAR: begin
                            open_next        = 1'b0;
                            open_fill_next   = '0;
                            entry_total_next = '0;
                            col_valid_next   = '0;
                            out_valid_next   = 1'b1;
                            out_idx_next     = '0;
                            out_sum_next     = '0;
                            out_last_next    = 1'b1;
                            out_sts_next     = STS_OK;
                        end
                        OP_INSERT: begin
                            if (ins_apply) begin
                                if (ins_opening) begin
                                    open_next       = 1'b1;
                                    open_col_next   = in_col;
                                    open_start_next = entry_total_reg;
                                    col_valid_next[in_col[CI_W-1:0]] = 1'b1;
                                end
                                col_we         = ins_opening || ins_store;
                                open_fill_next = fill_new;
                                if (ins_store) begin
                                    ent_we           = 1'b1;
                                    entry_total_next = entry_total_reg + 1'b1;
                                end
                            end
                            out_valid_next = 1'b1;
                            out_idx_next   = in_col;
                            out_sum_next   = '0;
                            out_last_next  = 1'b1;
                            out_sts_next   = ins_sts;
                        end
                        OP_LOAD: begin
                            if (32'(in_row) >= MAX_DIM) begin
                                out_sts_next = STS_RANGE;
                            end else begin
                                vec_we       = 1'b1;
                                out_sts_next = STS_OK;
                            end
                            out_valid_next = 1'b1;
                            out_idx_next   = in_row;
                            out_sum_next   = '0;
                            out_last_next  = 1'b1;
                        end
                        OP_XM: begin
                            mode_mx_next = 1'b0;
                            idx_next     = '0;
                            acc_next     = '0;
                            state_next   = S_COL_RD;
                        end
                        OP_MX: begin
                            mode_mx_next   = 1'b1;
                            idx_next       = '0;
                            sum_valid_next = '0;
                            state_next     = S_COL_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // fetch column descriptor and, for Mx, its vector element
            S_COL_RD: begin
                col_re     = 1'b1;
                vec_re     = 1'b1;
                state_next = S_COL_WAIT;
            end
            S_COL_WAIT: begin
                if (col_valid_reg[idx_reg] && (col_fill_q != '0)) begin
                    ptr_next   = col_start_q[AW-1:0];
                    rem_next   = col_fill_q;
                    vcol_next  = vec_q_reg;
                    state_next = S_ENT_RD;
                end else begin
                    state_next = S_COL_END;
                end
            end
            S_ENT_RD: begin
                ent_re     = 1'b1;
                state_next = S_ENT_WAIT;
            end
            // entry arrives: skip rows out of use, else fetch the second operand
            S_ENT_WAIT: begin
                if (row_skip) begin
                    ptr_next   = ptr_reg + 1'b1;
                    rem_next   = rem_reg - 1'b1;
                    state_next = ent_last ? S_COL_END : S_ENT_RD;
                end else begin
                    er_next    = ent_row_q[CI_W-1:0];
                    val_next   = ent_val_q;
                    vec_raddr  = ent_row_q[CI_W-1:0];
                    sum_raddr  = ent_row_q[CI_W-1:0];
                    vec_re     = !mode_mx_reg;
                    sum_re     = mode_mx_reg;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                mul_req.en = 1'b1;
                state_next = S_ACC;
            end
            // accumulate into the column sum or write back the row sum
            S_ACC: begin
                if (mode_mx_reg) begin
                    sum_we                 = 1'b1;
                    sum_valid_next[er_reg] = 1'b1;
                end else begin
                    acc_next = sat_add(acc_reg, prod);
                end
                ptr_next   = ptr_reg + 1'b1;
                rem_next   = rem_reg - 1'b1;
                state_next = ent_last ? S_COL_END : S_ENT_RD;
            end
            S_COL_END: begin
                if (!mode_mx_reg) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_idx_next   = IDX_W'(idx_reg);
                        out_sum_next   = acc_reg;
                        out_last_next  = col_last;
                        out_sts_next   = STS_OK;
                        acc_next       = '0;
                        if (col_last) begin
                            state_next = S_IDLE;
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_COL_RD;
                        end
                    end
                end else if (col_last) begin
                    idx_next   = '0;
                    state_next = S_OUT_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_COL_RD;
                end
            end
            // Mx row sums go out in row order
            S_OUT_RD: begin
                sum_re     = 1'b1;
                state_next = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_idx_next   = IDX_W'(idx_reg);
                    out_sum_next   = sum_valid_reg[idx_reg] ? sum_q_reg : '0;
                    out_last_next  = row_last;
                    out_sts_next   = STS_OK;
                    if (row_last) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            mode_mx_reg     <= 1'b0;
            idx_reg         <= '0;
            open_reg        <= 1'b0;
            open_fill_reg   <= '0;
            entry_total_reg <= '0;
            col_valid_reg   <= '0;
            sum_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
            rem_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            mode_mx_reg     <= mode_mx_next;
            idx_reg         <= idx_next;
            open_reg        <= open_next;
            open_fill_reg   <= open_fill_next;
            entry_total_reg <= entry_total_next;
            col_valid_reg   <= col_valid_next;
            sum_valid_reg   <= sum_valid_next;
            out_valid_reg   <= out_valid_next;
            rem_reg         <= rem_next;
        end
        acc_reg        <= acc_next;
        ptr_reg        <= ptr_next;
        er_reg         <= er_next;
        val_reg        <= val_next;
        vcol_reg       <= vcol_next;
        open_col_reg   <= open_col_next;
        open_start_reg <= open_start_next;
        out_idx_reg    <= out_idx_next;
        out_sum_reg    <= out_sum_next;
        out_last_reg   <= out_last_next;
        out_sts_reg    <= out_sts_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= DIMR_W'(64);
            col_count_reg <= DIMR_W'(64);
            thresh_reg    <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_ROWS) begin
                row_count_reg <= cfg_data[DIMR_W-1:0];
            end
            if (cfg_index == CFG_COLS) begin
                col_count_reg <= cfg_data[DIMR_W-1:0];
            end
            if (cfg_index == CFG_THRESH) begin
                thresh_reg <= cfg_data;
            end
        end
    end

    // column descriptors: start and fill
    always_ff @(posedge aclk) begin
        if (col_we) begin
            col_mem[col_waddr] <= col_wdata;
        end
        if (col_re) begin
            col_q_reg <= col_mem[col_raddr];
        end
    end

    // entry store: row and value
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            ent_q_reg <= ent_mem[ent_raddr];
        end
    end

    // vector store
    always_ff @(posedge aclk) begin
        if (vec_we) begin
            vec_mem[vec_waddr] <= vec_wdata;
        end
        if (vec_re) begin
            vec_q_reg <= vec_mem[vec_raddr];
        end
    end

    // row sums for Mx
    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        if (sum_re) begin
            sum_q_reg <= sum_mem[sum_raddr];
        end
    end

    csc_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    // checks
    `CSC_NEVER(a_total_bound, 32'(entry_total_reg) > MAX_NONZERO, "entry count above store size")
    `CSC_NEVER(a_fill_bound, 32'(open_fill_reg) > MAX_DIM, "open column fill above row limit")
    `CSC_ASSERT(a_total_step, (entry_total_reg != $past(entry_total_reg)) |-> ((entry_total_reg == $past(entry_total_reg) + 1'b1) || (entry_total_reg == '0)), "entry count moved by other than one")
    `CSC_ASSERT(a_run_no_input, (state_reg != S_IDLE) |=> (!$past(s_acc)), "item taken during a run")

endmodule
